@@ sv/umc_pkg.sv @@
// Shared types and constants for the universal machine core.
// Holds the controller/datapath action codes, opcodes, status and fault codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package umc_pkg;

	localparam int REG_COUNT = 8;
	localparam int RIDX_W    = 3;
	localparam int WORD_W    = 32;
	localparam int LADDR_W   = 12;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;

	// opcodes
	localparam logic [3:0] OP_CMOV   = 4'd0;
	localparam logic [3:0] OP_LOAD   = 4'd1;
	localparam logic [3:0] OP_STORE  = 4'd2;
	localparam logic [3:0] OP_ADD    = 4'd3;
	localparam logic [3:0] OP_MUL    = 4'd4;
	localparam logic [3:0] OP_DIV    = 4'd5;
	localparam logic [3:0] OP_NAND   = 4'd6;
	localparam logic [3:0] OP_MAP    = 4'd8;
	localparam logic [3:0] OP_UNMAP  = 4'd9;
	localparam logic [3:0] OP_OUT    = 4'd10;
	localparam logic [3:0] OP_LDPROG = 4'd12;
	localparam logic [3:0] OP_IMM    = 4'd13;

	// run status
	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_HALT  = 2'd1;
	localparam logic [1:0] ST_FAULT = 2'd2;

	// fault codes
	localparam logic [2:0] F_NONE   = 3'd0;
	localparam logic [2:0] F_ACCESS = 3'd1;
	localparam logic [2:0] F_DIV0   = 3'd2;
	localparam logic [2:0] F_NOID   = 3'd3;
	localparam logic [2:0] F_BIG    = 3'd4;
	localparam logic [2:0] F_PC     = 3'd5;

	// datapath actions
	localparam int ACT_W = 5;
	localparam logic [ACT_W-1:0] ACT_NONE   = 5'd0;
	localparam logic [ACT_W-1:0] ACT_LATCH  = 5'd1;
	localparam logic [ACT_W-1:0] ACT_WPROG  = 5'd2;
	localparam logic [ACT_W-1:0] ACT_FETCH  = 5'd3;
	localparam logic [ACT_W-1:0] ACT_IRW    = 5'd4;
	localparam logic [ACT_W-1:0] ACT_RDB    = 5'd5;
	localparam logic [ACT_W-1:0] ACT_RDC    = 5'd6;
	localparam logic [ACT_W-1:0] ACT_RDD    = 5'd7;
	localparam logic [ACT_W-1:0] ACT_LOOK   = 5'd8;
	localparam logic [ACT_W-1:0] ACT_EXEC   = 5'd9;
	localparam logic [ACT_W-1:0] ACT_LOADW  = 5'd10;
	localparam logic [ACT_W-1:0] ACT_MULW   = 5'd11;
	localparam logic [ACT_W-1:0] ACT_DIV    = 5'd12;
	localparam logic [ACT_W-1:0] ACT_DIVW   = 5'd13;
	localparam logic [ACT_W-1:0] ACT_POPW   = 5'd14;
	localparam logic [ACT_W-1:0] ACT_ZERO   = 5'd15;
	localparam logic [ACT_W-1:0] ACT_MAPFIN = 5'd16;
	localparam logic [ACT_W-1:0] ACT_COPY   = 5'd17;
	localparam logic [ACT_W-1:0] ACT_JUMP   = 5'd18;
	localparam logic [ACT_W-1:0] ACT_ADV    = 5'd19;
	localparam logic [ACT_W-1:0] ACT_FIN    = 5'd20;

	typedef struct packed {
		logic [ACT_W-1:0] act;
	} umc_cmd_t;

	typedef struct packed {
		logic       req_exec;
		logic       stopped;
		logic [3:0] op;
		logic       pc_bad;
		logic       acc_ok;
		logic       rc_zero;
		logic       map_big;
		logic       pop_ok;
		logic       fresh_ok;
		logic       unmap_ok;
		logic       src_zero;
		logic       src_ok;
		logic       sweep_done;
		logic       div_last;
		logic       out_free;
	} umc_stat_t;

endpackage
`default_nettype wire

@@ sv/umc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module umc_ram #(
	parameter int WIDTH = 32,
	parameter longint unsigned DEPTH = 8
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ sv/umc_ctrl.sv @@
// Sequencing state machine of the universal machine core.
// Depends on umc_pkg for action codes, opcodes and the status struct.
`timescale 1ns / 1ps
`default_nettype none
module umc_ctrl
	import umc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_axis_tvalid,
	output logic           s_axis_tready,
	input  wire umc_stat_t stat,
	output umc_cmd_t       cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_WPROG  = 5'd2;
	localparam logic [4:0] S_FETCH  = 5'd3;
	localparam logic [4:0] S_IRW    = 5'd4;
	localparam logic [4:0] S_RDB    = 5'd5;
	localparam logic [4:0] S_RDC    = 5'd6;
	localparam logic [4:0] S_RDD    = 5'd7;
	localparam logic [4:0] S_LOOK   = 5'd8;
	localparam logic [4:0] S_EXEC   = 5'd9;
	localparam logic [4:0] S_LOADW  = 5'd10;
	localparam logic [4:0] S_MULW   = 5'd11;
	localparam logic [4:0] S_DIV    = 5'd12;
	localparam logic [4:0] S_DIVW   = 5'd13;
	localparam logic [4:0] S_POPW   = 5'd14;
	localparam logic [4:0] S_ZERO   = 5'd15;
	localparam logic [4:0] S_MAPFIN = 5'd16;
	localparam logic [4:0] S_COPY   = 5'd17;
	localparam logic [4:0] S_JUMP   = 5'd18;
	localparam logic [4:0] S_ADV    = 5'd19;
	localparam logic [4:0] S_FIN    = 5'd20;

	logic [4:0] state_q, state_d;

	assign s_axis_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.act = ACT_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.act = ACT_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				priority if (!stat.req_exec) state_d = S_WPROG;
				else if (stat.stopped)       state_d = S_FIN;
				else                         state_d = S_FETCH;
			end
			S_WPROG: begin
				cmd.act = ACT_WPROG;
				state_d = S_FIN;
			end
			S_FETCH: begin
				cmd.act = ACT_FETCH;
				state_d = stat.pc_bad ? S_FIN : S_IRW;
			end
			S_IRW: begin
				cmd.act = ACT_IRW;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.act = ACT_RDB;
				state_d = S_RDC;
			end
			S_RDC: begin
				cmd.act = ACT_RDC;
				state_d = S_RDD;
			end
			S_RDD: begin
				cmd.act = ACT_RDD;
				state_d = S_LOOK;
			end
			S_LOOK: begin
				cmd.act = ACT_LOOK;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.act = ACT_EXEC;
				unique case (stat.op)
					OP_CMOV, OP_ADD, OP_NAND, OP_OUT, OP_IMM: state_d = S_ADV;
					OP_LOAD:   state_d = stat.acc_ok ? S_LOADW : S_FIN;
					OP_STORE:  state_d = stat.acc_ok ? S_ADV : S_FIN;
					OP_MUL:    state_d = S_MULW;
					OP_DIV:    state_d = stat.rc_zero ? S_FIN : S_DIV;
					OP_MAP: begin
						priority if (stat.map_big) state_d = S_FIN;
						else if (stat.pop_ok)      state_d = S_POPW;
						else if (stat.fresh_ok)    state_d = S_ZERO;
						else                       state_d = S_FIN;
					end
					OP_UNMAP:  state_d = stat.unmap_ok ? S_ADV : S_FIN;
					OP_LDPROG: begin
						priority if (stat.src_zero) state_d = S_JUMP;
						else if (stat.src_ok)       state_d = S_COPY;
						else                        state_d = S_FIN;
					end
					default:   state_d = S_FIN;
				endcase
			end
			S_LOADW: begin
				cmd.act = ACT_LOADW;
				state_d = S_ADV;
			end
			S_MULW: begin
				cmd.act = ACT_MULW;
				state_d = S_ADV;
			end
			S_DIV: begin
				cmd.act = ACT_DIV;
				if (stat.div_last) state_d = S_DIVW;
			end
			S_DIVW: begin
				cmd.act = ACT_DIVW;
				state_d = S_ADV;
			end
			S_POPW: begin
				cmd.act = ACT_POPW;
				state_d = S_ZERO;
			end
			S_ZERO: begin
				cmd.act = ACT_ZERO;
				if (stat.sweep_done) state_d = S_MAPFIN;
			end
			S_MAPFIN: begin
				cmd.act = ACT_MAPFIN;
				state_d = S_ADV;
			end
			S_COPY: begin
				cmd.act = ACT_COPY;
				if (stat.sweep_done) state_d = S_JUMP;
			end
			S_JUMP: begin
				cmd.act = ACT_JUMP;
				state_d = S_FIN;
			end
			S_ADV: begin
				cmd.act = ACT_ADV;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.act = ACT_FIN;
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/umc_dpath.sv @@
// Datapath of the universal machine core: register file, segment memory,
// segment table, free-id stack, divider and result register.
// Depends on umc_pkg and umc_ram.
`timescale 1ns / 1ps
`default_nettype none
module umc_dpath
	import umc_pkg::*;
#(
	parameter int NUM_SEGS  = 64,
	parameter int SEG_WORDS = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire umc_cmd_t              cmd,
	output umc_stat_t                  stat,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic                  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                       m_axis_tuser
);

	localparam int ID_W   = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
	localparam int OFF_W  = $clog2(SEG_WORDS);
	localparam int LEN_W  = $clog2(SEG_WORDS + 1);
	localparam int CNT_W  = $clog2(NUM_SEGS + 1);
	localparam int ADDR_W = ID_W + OFF_W;
	localparam longint unsigned MEM_DEPTH = longint'(NUM_SEGS) << OFF_W;

	// latched request
	logic               req_q;
	logic [LADDR_W-1:0] ld_addr_q;
	logic [WORD_W-1:0]  ld_word_q;

	// architectural control state
	logic [LEN_W-1:0]     pc_q, len0_q;
	logic [1:0]           halt_q;
	logic [2:0]           fault_q;
	logic [CNT_W-1:0]     cnt_q, fresh_q;
	logic [REG_COUNT-1:0] rvalid_q;

	// instruction and operands
	logic [WORD_W-1:0] ir_q, ra_q, rb_q, rc_q;
	logic              rf_vld_q;

	// sweeps, multiply, divide
	logic [ID_W-1:0]   seg_id_q;
	logic [LEN_W-1:0]  sweep_len_q, idx_q;
	logic [WORD_W-1:0] prod_q, quo_q, rem_q;
	logic [4:0]        dcnt_q;

	// pending char and output register
	logic       pch_v_q, m_tvalid_q, oc_v_q;
	logic [7:0] pch_q, oc_q;
	logic [1:0] ost_q;
	logic [2:0] ofc_q;

	// RAM ports
	logic              rf_we;
	logic [RIDX_W-1:0] rf_waddr, rf_raddr;
	logic [WORD_W-1:0] rf_wdata, rf_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata, mem_q;
	logic              tbl_we;
	logic [ID_W-1:0]   tbl_waddr, tbl_raddr;
	logic [LEN_W:0]    tbl_wdata, tbl_q;
	logic              stk_we;
	logic [ID_W-1:0]   stk_waddr, stk_raddr, stk_q;

	// decode and checks
	logic [3:0]        op;
	logic [RIDX_W-1:0] fa, fb, fc;
	logic [WORD_W-1:0] sel_id, sel_off, rf_rd, addr32, addr_p1, full_word;
	logic [63:0]       prod_full;
	logic              id_in, id_zero, mapped, acc_ok, unmap_ok, src_ok;
	logic              map_big, pop_ok, fresh_ok, push_ok, pc_bad, jump_bad;
	logic              addr_ok, sweep_done, out_free, is_exec;
	logic [LEN_W-1:0]  sel_len, idx_m1;
	logic [CNT_W-1:0]  cnt_m1;
	logic [WORD_W:0]   dtrial, ddiff;
	logic              flt_set, halt_set;
	logic [2:0]        flt_code;

	assign op   = ir_q[31:28];
	assign fa   = ir_q[8:6];
	assign fb   = ir_q[5:3];
	assign fc   = ir_q[2:0];
	assign is_exec = (cmd.act == ACT_EXEC);
	assign rf_rd   = rf_vld_q ? rf_q : '0;

	always_comb begin
		unique case (op)
			OP_LOAD, OP_LDPROG: sel_id = rb_q;
			OP_STORE:           sel_id = ra_q;
			default:            sel_id = rc_q;
		endcase
		sel_off = (op == OP_STORE) ? rb_q : rc_q;
	end

	assign id_in    = sel_id < 32'(NUM_SEGS);
	assign id_zero  = (sel_id == '0);
	assign mapped   = id_zero || ((sel_id < 32'(fresh_q)) && tbl_q[LEN_W]);
	assign sel_len  = id_zero ? len0_q : tbl_q[LEN_W-1:0];
	assign acc_ok   = id_in && mapped && (sel_off < 32'(sel_len));
	assign unmap_ok = !id_zero && id_in && mapped;
	assign src_ok   = id_in && mapped;
	assign map_big  = rc_q > 32'(SEG_WORDS);
	assign pop_ok   = (cnt_q != '0);
	assign fresh_ok = fresh_q < CNT_W'(NUM_SEGS);
	assign push_ok  = cnt_q < CNT_W'(NUM_SEGS);
	assign pc_bad   = pc_q >= len0_q;
	assign jump_bad = rc_q >= 32'(len0_q);
	assign addr32   = 32'(ld_addr_q);
	assign addr_p1  = addr32 + 32'd1;
	assign addr_ok  = addr32 < 32'(SEG_WORDS);
	assign sweep_done = (idx_q == sweep_len_q);
	assign idx_m1   = idx_q - 1'b1;
	assign cnt_m1   = cnt_q - 1'b1;
	assign out_free = !m_tvalid_q || m_axis_tready;
	assign prod_full = rb_q * rc_q;
	assign dtrial   = {rem_q, quo_q[WORD_W-1]};
	assign ddiff    = dtrial - {1'b0, rc_q};
	assign full_word = {7'd0, ir_q[24:0]};

	assign stat.req_exec   = req_q;
	assign stat.stopped    = (halt_q != ST_RUN);
	assign stat.op         = op;
	assign stat.pc_bad     = pc_bad;
	assign stat.acc_ok     = acc_ok;
	assign stat.rc_zero    = (rc_q == '0);
	assign stat.map_big    = map_big;
	assign stat.pop_ok     = pop_ok;
	assign stat.fresh_ok   = fresh_ok;
	assign stat.unmap_ok   = unmap_ok;
	assign stat.src_zero   = (rb_q == '0);
	assign stat.src_ok     = src_ok;
	assign stat.sweep_done = sweep_done;
	assign stat.div_last   = &dcnt_q;
	assign stat.out_free   = out_free;

	// faults and halts
	always_comb begin
		flt_set  = 1'b0;
		flt_code = F_NONE;
		halt_set = 1'b0;
		if (cmd.act == ACT_FETCH && pc_bad) begin
			flt_set  = 1'b1;
			flt_code = F_PC;
		end
		if (cmd.act == ACT_JUMP && jump_bad) begin
			flt_set  = 1'b1;
			flt_code = F_PC;
		end
		if (is_exec) begin
			unique case (op)
				OP_CMOV, OP_ADD, OP_MUL, OP_NAND, OP_OUT, OP_IMM: ;
				OP_LOAD, OP_STORE: begin
					flt_set  = !acc_ok;
					flt_code = F_ACCESS;
				end
				OP_DIV: begin
					flt_set  = (rc_q == '0);
					flt_code = F_DIV0;
				end
				OP_MAP: begin
					flt_set  = map_big || (!pop_ok && !fresh_ok);
					flt_code = map_big ? F_BIG : F_NOID;
				end
				OP_UNMAP: begin
					flt_set  = !unmap_ok;
					flt_code = F_ACCESS;
				end
				OP_LDPROG: begin
					flt_set  = (rb_q != '0) && !src_ok;
					flt_code = F_ACCESS;
				end
				default: halt_set = 1'b1;
			endcase
		end
	end

	// register file ports
	always_comb begin
		unique case (cmd.act)
			ACT_IRW: rf_raddr = mem_q[8:6];
			ACT_RDB: rf_raddr = fb;
			ACT_RDC: rf_raddr = fc;
			default: rf_raddr = fa;
		endcase
		rf_we    = 1'b0;
		rf_waddr = fa;
		rf_wdata = rb_q;
		unique case (cmd.act)
			ACT_EXEC: begin
				unique case (op)
					OP_CMOV: rf_we = (rc_q != '0);
					OP_ADD: begin
						rf_we    = 1'b1;
						rf_wdata = rb_q + rc_q;
					end
					OP_NAND: begin
						rf_we    = 1'b1;
						rf_wdata = ~(rb_q & rc_q);
					end
					OP_IMM: begin
						rf_we    = 1'b1;
						rf_waddr = ir_q[27:25];
						rf_wdata = full_word;
					end
					default: rf_we = 1'b0;
				endcase
			end
			ACT_LOADW: begin
				rf_we    = 1'b1;
				rf_wdata = mem_q;
			end
			ACT_MULW: begin
				rf_we    = 1'b1;
				rf_wdata = prod_q;
			end
			ACT_DIVW: begin
				rf_we    = 1'b1;
				rf_wdata = quo_q;
			end
			ACT_MAPFIN: begin
				rf_we    = 1'b1;
				rf_waddr = fb;
				rf_wdata = 32'(seg_id_q);
			end
			default: rf_we = 1'b0;
		endcase
	end

	// segment memory ports
	always_comb begin
		unique case (cmd.act)
			ACT_EXEC: mem_raddr = {sel_id[ID_W-1:0], sel_off[OFF_W-1:0]};
			ACT_COPY: mem_raddr = {seg_id_q, idx_q[OFF_W-1:0]};
			default:  mem_raddr = {{ID_W{1'b0}}, pc_q[OFF_W-1:0]};
		endcase
		mem_we    = 1'b0;
		mem_waddr = {{ID_W{1'b0}}, addr32[OFF_W-1:0]};
		mem_wdata = ld_word_q;
		unique case (cmd.act)
			ACT_WPROG: mem_we = addr_ok;
			ACT_EXEC: begin
				mem_we    = (op == OP_STORE) && acc_ok;
				mem_waddr = {sel_id[ID_W-1:0], sel_off[OFF_W-1:0]};
				mem_wdata = rc_q;
			end
			ACT_ZERO: begin
				mem_we    = !sweep_done;
				mem_waddr = {seg_id_q, idx_q[OFF_W-1:0]};
				mem_wdata = '0;
			end
			ACT_COPY: begin
				mem_we    = (idx_q != '0);
				mem_waddr = {{ID_W{1'b0}}, idx_m1[OFF_W-1:0]};
				mem_wdata = mem_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	// segment table and free-id stack ports
	always_comb begin
		tbl_raddr = sel_id[ID_W-1:0];
		stk_raddr = cnt_m1[ID_W-1:0];
		stk_waddr = cnt_q[ID_W-1:0];
		stk_we    = is_exec && (op == OP_UNMAP) && unmap_ok && push_ok;
		if (cmd.act == ACT_MAPFIN) begin
			tbl_we    = 1'b1;
			tbl_waddr = seg_id_q;
			tbl_wdata = {1'b1, sweep_len_q};
		end else begin
			tbl_we    = is_exec && (op == OP_UNMAP) && unmap_ok;
			tbl_waddr = sel_id[ID_W-1:0];
			tbl_wdata = '0;
		end
	end

	umc_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_raddr), .rdata(rf_q)
	);

	umc_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_q)
	);

	umc_ram #(.WIDTH(LEN_W + 1), .DEPTH(NUM_SEGS)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tbl_raddr), .rdata(tbl_q)
	);

	umc_ram #(.WIDTH(ID_W), .DEPTH(NUM_SEGS)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(sel_id[ID_W-1:0]),
		.raddr(stk_raddr), .rdata(stk_q)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			len0_q     <= '0;
			halt_q     <= ST_RUN;
			fault_q    <= F_NONE;
			cnt_q      <= '0;
			fresh_q    <= CNT_W'(1);
			rvalid_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.act == ACT_WPROG && addr_ok && (32'(len0_q) < addr_p1)) begin
				len0_q <= addr_p1[LEN_W-1:0];
			end
			if (cmd.act == ACT_COPY && sweep_done) begin
				len0_q <= sweep_len_q;
			end
			if (cmd.act == ACT_ADV) begin
				pc_q <= pc_q + 1'b1;
			end
			if (cmd.act == ACT_JUMP && !jump_bad) begin
				pc_q <= rc_q[LEN_W-1:0];
			end
			if (flt_set) begin
				halt_q  <= ST_FAULT;
				fault_q <= flt_code;
			end
			if (halt_set) begin
				halt_q <= ST_HALT;
			end
			if (is_exec && op == OP_MAP && !map_big) begin
				if (pop_ok) begin
					cnt_q <= cnt_m1;
				end else if (fresh_ok) begin
					fresh_q <= fresh_q + 1'b1;
				end
			end
			if (stk_we) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (rf_we) begin
				rvalid_q[rf_waddr] <= 1'b1;
			end
			if (cmd.act == ACT_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rf_vld_q <= rvalid_q[rf_raddr];
		if (cmd.act == ACT_LATCH) begin
			req_q     <= s_axis_tuser;
			ld_addr_q <= s_axis_tdata[LADDR_W-1:0];
			ld_word_q <= s_axis_tdata[LADDR_W+WORD_W-1:LADDR_W];
			pch_v_q   <= 1'b0;
			pch_q     <= '0;
		end
		if (cmd.act == ACT_IRW) ir_q <= mem_q;
		if (cmd.act == ACT_RDB) ra_q <= rf_rd;
		if (cmd.act == ACT_RDC) rb_q <= rf_rd;
		if (cmd.act == ACT_RDD) rc_q <= rf_rd;
		if (is_exec) begin
			unique case (op)
				OP_MUL: prod_q <= prod_full[WORD_W-1:0];
				OP_DIV: begin
					quo_q  <= rb_q;
					rem_q  <= '0;
					dcnt_q <= '0;
				end
				OP_MAP: begin
					sweep_len_q <= rc_q[LEN_W-1:0];
					idx_q       <= '0;
					seg_id_q    <= fresh_q[ID_W-1:0];
				end
				OP_LDPROG: begin
					sweep_len_q <= tbl_q[LEN_W-1:0];
					idx_q       <= '0;
					seg_id_q    <= rb_q[ID_W-1:0];
				end
				OP_OUT: begin
					pch_v_q <= 1'b1;
					pch_q   <= rc_q[7:0];
				end
				default: ;
			endcase
		end
		if (cmd.act == ACT_DIV) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (!ddiff[WORD_W]) begin
				rem_q <= ddiff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= dtrial[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
		if (cmd.act == ACT_POPW) seg_id_q <= stk_q;
		if ((cmd.act == ACT_ZERO || cmd.act == ACT_COPY) && !sweep_done) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.act == ACT_FIN && out_free) begin
			oc_v_q <= pch_v_q;
			oc_q   <= pch_q;
			ost_q  <= halt_q;
			ofc_q  <= (halt_q == ST_FAULT) ? fault_q : F_NONE;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tuser  = oc_v_q;
	assign m_axis_tdata  = {3'd0, ofc_q, ost_q, oc_q};

endmodule
`default_nettype wire

@@ sv/universal_machine_core_unit.sv @@
// Universal machine core: 32-bit interpreter, eight registers, segmented memory.
// Program writes go through WPROG; instructions go through fetch to execute, with
// extra states for load, multiply, divide, map (plus POPW on a recycled id) and
// load program; one item at a time, next transfer in IDLE once FIN has finished.
// Reset (arst_n low) clears registers, pc, segment 0 length, id allocator and
// run status at once; segment memory is undefined until written, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module universal_machine_core_unit
	import umc_pkg::*;
#(
	parameter int NUM_SEGS  = 64,
	parameter int SEG_WORDS = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request channel
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // load_addr[11:0], load_word[43:12]
	input  wire logic                  s_axis_tuser,  // req_type
	// result channel
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,  // out_char[7:0], run_status[9:8],
	                                                  // fault_code[12:10]
	output logic                       m_axis_tuser   // out_char_valid
);

	// The controller steps through fetch, operand reads (one register-file
	// port, read data registered), table lookup and execute; long operations
	// (divide, zeroing sweep on map, copy on load program) loop in their own
	// states. The result register lets the next request transfer while a
	// result still waits on the output side.
	umc_cmd_t  cmd;
	umc_stat_t stat;

	umc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	umc_dpath #(
		.NUM_SEGS  (NUM_SEGS),
		.SEG_WORDS (SEG_WORDS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
`default_nettype wire
